>>> rtl/fmjg_pkg.sv
package fmjg_pkg;

    // Feed mode codes as they appear on the result channel.
    typedef enum logic [1:0] {
        MODE_STOP    = 2'd0,
        MODE_SINGLE  = 2'd1,
        MODE_BURST   = 2'd2,
        MODE_REVERSE = 2'd3
    } feed_mode_t;

    // Mode lever positions.
    localparam logic [1:0] LEVER_UP      = 2'd0;
    localparam logic [1:0] LEVER_MIDDLE  = 2'd1;
    localparam logic [1:0] LEVER_DOWN    = 2'd2;
    localparam logic [1:0] LEVER_INVALID = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALL_SPEED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STALL_LIMIT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_LIMIT  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLYWHEEL_MIN   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEAT_MARGIN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TO_BURST  = 3'd5;

    localparam int CFG_DATA_W = 16;
    localparam int SPEED_CFG_W = 15;
    localparam int TICK_W = 16;
    localparam int HEAT_W = 16;
    localparam int HOLD_W = 8;

    localparam logic [SPEED_CFG_W-1:0] RST_STALL_SPEED   = 15'd100;
    localparam logic [TICK_W-1:0]      RST_STALL_LIMIT   = 16'd500;
    localparam logic [TICK_W-1:0]      RST_REVERSE_LIMIT = 16'd100;
    localparam logic [SPEED_CFG_W-1:0] RST_FLYWHEEL_MIN  = 15'd1000;
    localparam logic [HEAT_W-1:0]      RST_HEAT_MARGIN   = 16'd10;
    localparam logic [HOLD_W-1:0]      RST_HOLD_TO_BURST = 8'd180;

    // Result item: five bits packed into one byte.
    localparam int OUT_BITS = 5;
    localparam int OUT_W = 8;

endpackage

>>> rtl/feeder_mode_jam_guard.sv
// Feed-mode and flywheel-enable decision for a flywheel launcher, one item per
// control tick.
// Input channel s_tvalid/s_tready/s_tdata carries the lever, keys, buttons,
// fire command, feeder and flywheel speeds, heat reading and heat limit.
// Output channel m_tvalid/m_tready/m_tdata carries one result item per input
// item: flywheel enable, feed mode, flywheel at speed and index start.
// Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per cycle; the user must write it only while no item is in flight, as the
// block itself does not enforce this. An item is held in the input register
// and is decided on the way into the result register. Throughput is one item
// per cycle while the receiver does not stall; the only loop is the tick state
// (mode, latch, counters) updated in the same cycle as the result register.
// When the receiver stalls, the result register holds, the input register
// fills and s_tready drops; nothing is lost or repeated.
// Reset clears all tick state and both valid flags and loads the register
// defaults (stall speed 100, stall limit 500, reverse limit 100, flywheel
// minimum 1000, heat margin 10, hold to burst 180).
module feeder_mode_jam_guard #(
    parameter int SPEED_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // mode_switch[2], force_safe, key_start, key_stop, left_button,
    // right_button, fire_command, feeder_speed, flywheel_speed, heat_now[16],
    // heat_cap[16], index_error_open, zero fill
    input  logic [((2*SPEED_WIDTH+48)/8)*8-1:0]   s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // flywheel_enable, feed_mode[2], flywheel_at_speed, index_start, zero fill
    output logic [fmjg_pkg::OUT_W-1:0]            m_tdata,
    input  logic                                  cfg_we,
    input  logic [fmjg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fmjg_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import fmjg_pkg::*;

    localparam int IN_BITS = 2 * SPEED_WIDTH + 41;
    localparam int FEED_LO = 8;
    localparam int FLY_LO = FEED_LO + SPEED_WIDTH;
    localparam int HEAT_LO = FLY_LO + SPEED_WIDTH;
    localparam int CAP_LO = HEAT_LO + HEAT_W;
    localparam int ERR_BIT = CAP_LO + HEAT_W;
    localparam int CMP_W = (SPEED_WIDTH > SPEED_CFG_W) ? SPEED_WIDTH : SPEED_CFG_W;

    // Configuration registers.
    logic [SPEED_CFG_W-1:0] stall_speed_reg;
    logic [TICK_W-1:0]      stall_limit_reg;
    logic [TICK_W-1:0]      reverse_limit_reg;
    logic [SPEED_CFG_W-1:0] flywheel_min_reg;
    logic [HEAT_W-1:0]      heat_margin_reg;
    logic [HOLD_W-1:0]      hold_limit_reg;

    // Tick state.
    logic                   latch_reg, latch_next;
    logic                   flywheel_on_reg, flywheel_on_next;
    feed_mode_t             mode_now_reg, mode_now_next;
    logic                   prev_left_reg, prev_left_next;
    logic                   moving_reg, moving_next;
    logic [HOLD_W-1:0]      hold_reg, hold_next;
    logic [TICK_W-1:0]      stall_reg, stall_next;
    logic [TICK_W-1:0]      reverse_reg, reverse_next;

    // Input and result registers.
    logic                   in_valid_reg;
    logic [IN_BITS-1:0]     in_data_reg;
    logic                   out_valid_reg;
    logic                   out_enable_reg;
    feed_mode_t             out_mode_reg;
    logic                   out_at_speed_reg;
    logic                   out_start_reg;

    logic                   advance;
    logic                   at_speed;
    logic                   index_start;

    logic [1:0]             lever;
    logic                   force_safe;
    logic                   key_start;
    logic                   key_stop;
    logic                   left_button;
    logic                   right_button;
    logic                   fire_command;
    logic [SPEED_WIDTH-1:0] feeder_speed;
    logic [SPEED_WIDTH-1:0] flywheel_speed;
    logic [HEAT_W-1:0]      heat_now;
    logic [HEAT_W-1:0]      heat_cap;
    logic                   index_error_open;
    logic [SPEED_WIDTH-1:0] feed_mag;
    logic [SPEED_WIDTH-1:0] fly_mag;
    logic                   feed_slow;
    logic                   heat_over;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, out_start_reg, out_at_speed_reg,
                       out_mode_reg, out_enable_reg};

    assign lever            = in_data_reg[1:0];
    assign force_safe       = in_data_reg[2];
    assign key_start        = in_data_reg[3];
    assign key_stop         = in_data_reg[4];
    assign left_button      = in_data_reg[5];
    assign right_button     = in_data_reg[6];
    assign fire_command     = in_data_reg[7];
    assign feeder_speed     = in_data_reg[FEED_LO +: SPEED_WIDTH];
    assign flywheel_speed   = in_data_reg[FLY_LO +: SPEED_WIDTH];
    assign heat_now         = in_data_reg[HEAT_LO +: HEAT_W];
    assign heat_cap         = in_data_reg[CAP_LO +: HEAT_W];
    assign index_error_open = in_data_reg[ERR_BIT];

    // Exact magnitude: the most negative value maps to 2^(SPEED_WIDTH-1).
    assign feed_mag = feeder_speed[SPEED_WIDTH-1] ? (~feeder_speed + SPEED_WIDTH'(1))
                                                  : feeder_speed;
    assign fly_mag  = flywheel_speed[SPEED_WIDTH-1] ? (~flywheel_speed + SPEED_WIDTH'(1))
                                                    : flywheel_speed;

    assign feed_slow = CMP_W'(feed_mag) < CMP_W'(stall_speed_reg);
    assign at_speed  = !(CMP_W'(fly_mag) < CMP_W'(flywheel_min_reg));
    assign heat_over = ({1'b0, heat_now} + {1'b0, heat_margin_reg}) > {1'b0, heat_cap};

    always_comb
    begin
        latch_next       = latch_reg;
        flywheel_on_next = flywheel_on_reg;
        mode_now_next    = mode_now_reg;
        prev_left_next   = prev_left_reg;
        moving_next      = moving_reg;
        hold_next        = hold_reg;
        stall_next       = stall_reg;
        reverse_next     = reverse_reg;
        index_start      = 1'b0;

        case (lever)
            LEVER_UP:
            begin
                flywheel_on_next = 1'b0;
                mode_now_next    = MODE_STOP;
            end
            LEVER_MIDDLE:
            begin
                if (key_start)
                begin
                    latch_next = 1'b1;
                end
                else if (key_stop)
                begin
                    latch_next = 1'b0;
                end
                flywheel_on_next = latch_next;

                if (left_button && !prev_left_reg)
                begin
                    mode_now_next = MODE_SINGLE;
                end
                else if (right_button)
                begin
                    mode_now_next = fire_command ? MODE_BURST : MODE_STOP;
                end
                else
                begin
                    mode_now_next = MODE_STOP;
                end
                prev_left_next = left_button;

                // A shot still in motion keeps the single-shot mode.
                if (moving_reg)
                begin
                    mode_now_next = MODE_SINGLE;
                end

                if (left_button)
                begin
                    if (hold_reg < hold_limit_reg)
                    begin
                        hold_next = hold_reg + HOLD_W'(1);
                    end
                    else
                    begin
                        mode_now_next = MODE_BURST;
                        moving_next   = 1'b0;
                    end
                end
                else
                begin
                    hold_next = '0;
                end
            end
            LEVER_DOWN:
            begin
                flywheel_on_next = 1'b1;
                mode_now_next    = MODE_BURST;
            end
            default:
            begin
            end
        endcase

        // Jam guard: a long stall forces reverse for a bounded number of ticks.
        if (mode_now_next == MODE_BURST || mode_now_next == MODE_SINGLE)
        begin
            if (stall_reg >= stall_limit_reg)
            begin
                mode_now_next = MODE_REVERSE;
            end
            if (feed_slow && stall_reg < stall_limit_reg)
            begin
                stall_next   = stall_reg + TICK_W'(1);
                reverse_next = '0;
            end
            else if (stall_reg == stall_limit_reg && reverse_reg < reverse_limit_reg)
            begin
                reverse_next = reverse_reg + TICK_W'(1);
            end
            else
            begin
                stall_next = '0;
            end
        end

        if (!at_speed || heat_over)
        begin
            mode_now_next = MODE_STOP;
        end

        if (force_safe)
        begin
            mode_now_next    = MODE_STOP;
            flywheel_on_next = 1'b0;
        end

        if (mode_now_next == MODE_SINGLE)
        begin
            index_start = !moving_next;
            moving_next = index_error_open;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_speed_reg   <= RST_STALL_SPEED;
            stall_limit_reg   <= RST_STALL_LIMIT;
            reverse_limit_reg <= RST_REVERSE_LIMIT;
            flywheel_min_reg  <= RST_FLYWHEEL_MIN;
            heat_margin_reg   <= RST_HEAT_MARGIN;
            hold_limit_reg    <= RST_HOLD_TO_BURST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STALL_SPEED:   stall_speed_reg   <= cfg_data[SPEED_CFG_W-1:0];
                CFG_STALL_LIMIT:   stall_limit_reg   <= cfg_data[TICK_W-1:0];
                CFG_REVERSE_LIMIT: reverse_limit_reg <= cfg_data[TICK_W-1:0];
                CFG_FLYWHEEL_MIN:  flywheel_min_reg  <= cfg_data[SPEED_CFG_W-1:0];
                CFG_HEAT_MARGIN:   heat_margin_reg   <= cfg_data[HEAT_W-1:0];
                CFG_HOLD_TO_BURST: hold_limit_reg    <= cfg_data[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg       <= 1'b0;
            flywheel_on_reg <= 1'b0;
            mode_now_reg    <= MODE_STOP;
            prev_left_reg   <= 1'b0;
            moving_reg      <= 1'b0;
            hold_reg        <= '0;
            stall_reg       <= '0;
            reverse_reg     <= '0;
        end
        else if (advance)
        begin
            latch_reg       <= latch_next;
            flywheel_on_reg <= flywheel_on_next;
            mode_now_reg    <= mode_now_next;
            prev_left_reg   <= prev_left_next;
            moving_reg      <= moving_next;
            hold_reg        <= hold_next;
            stall_reg       <= stall_next;
            reverse_reg     <= reverse_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (advance)
        begin
            out_enable_reg   <= flywheel_on_next;
            out_mode_reg     <= mode_now_next;
            out_at_speed_reg <= at_speed;
            out_start_reg    <= index_start;
        end
    end

    // A new index target is only requested in single-shot mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_start_reg |-> out_mode_reg == MODE_SINGLE)
        else $error("index start outside single-shot mode");

    // A flywheel below minimum speed never lets the feeder run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_at_speed_reg |-> out_mode_reg == MODE_STOP)
        else $error("feeder running with slow flywheel");

    // The shown result matches the tick state it left behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_mode_reg == mode_now_reg
                          && out_enable_reg == flywheel_on_reg)
        else $error("result and tick state disagree");

    // Tick state moves only when an item is decided.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stall_reg) && $stable(hold_reg) && $stable(mode_now_reg))
        else $error("tick state changed without an item");

    // A blocked item stays in the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("blocked item dropped");

endmodule

>>> tb/sv/feeder_mode_jam_guard_tb.sv
`timescale 1ns / 1ps

module feeder_mode_jam_guard_tb;

    import fmjg_pkg::*;

    localparam int IN_W = 80;

    typedef struct {
        logic [1:0]         lever;
        logic               safe;
        logic               key_start;
        logic               key_stop;
        logic               left;
        logic               right;
        logic               fire;
        logic signed [15:0] feeder;
        logic signed [15:0] flywheel;
        logic [15:0]        heat_now;
        logic [15:0]        heat_cap;
        logic               err_open;
    } tick_t;

    typedef struct {
        logic       fw_en;
        feed_mode_t mode;
        logic       at_speed;
        logic       index_start;
    } decision_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // mode_switch[2], force_safe, key_start, key_stop, left_button, right_button,
    // fire_command, feeder_speed[16], flywheel_speed[16], heat_now[16],
    // heat_cap[16], index_error_open, zero fill
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // flywheel_enable, feed_mode[2], flywheel_at_speed, index_start, zero fill
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Register copies held by the predictor.
    logic [14:0] stall_speed_thr;
    logic [15:0] stall_limit;
    logic [15:0] reverse_limit;
    logic [14:0] flywheel_min;
    logic [15:0] heat_margin;
    logic [7:0]  hold_limit;

    // Tick state held by the predictor.
    logic        latch_q;
    logic        flywheel_on_q;
    feed_mode_t  mode_q;
    logic        prev_left_q;
    logic        shot_moving_q;
    logic [7:0]  hold_count;
    logic [15:0] stall_count;
    logic [15:0] reverse_count;

    decision_t pending_decisions[$];
    int        mismatch_count = 0;
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    int        receiver_hold_cycles = 0;
    logic      left_level = 1'b0;

    feeder_mode_jam_guard #(
        .SPEED_WIDTH(16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("feeder_mode_jam_guard_tb: FAIL");
        $finish;
    end

    function automatic logic [16:0] magnitude(logic signed [15:0] v);
        return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
    endfunction

    function automatic logic [IN_W-1:0] pack_tick(tick_t t);
        return {7'b0, t.err_open, t.heat_cap, t.heat_now, t.flywheel, t.feeder,
                t.fire, t.right, t.left, t.key_stop, t.key_start, t.safe, t.lever};
    endfunction

    function automatic decision_t decide_tick(tick_t t);
        decision_t   d;
        logic [16:0] feed_mag;
        logic [16:0] fly_mag;
        feed_mag      = magnitude(t.feeder);
        fly_mag       = magnitude(t.flywheel);
        d.index_start = 1'b0;
        case (t.lever)
            LEVER_UP:
            begin
                flywheel_on_q = 1'b0;
                mode_q        = MODE_STOP;
            end
            LEVER_MIDDLE:
            begin
                if (t.key_start)
                    latch_q = 1'b1;
                else if (t.key_stop)
                    latch_q = 1'b0;
                flywheel_on_q = latch_q;
                if (t.left && !prev_left_q)
                    mode_q = MODE_SINGLE;
                else if (t.right)
                    mode_q = t.fire ? MODE_BURST : MODE_STOP;
                else
                    mode_q = MODE_STOP;
                prev_left_q = t.left;
                if (shot_moving_q)
                    mode_q = MODE_SINGLE;
                if (t.left)
                begin
                    if (hold_count < hold_limit)
                        hold_count = hold_count + 8'd1;
                    else
                    begin
                        mode_q        = MODE_BURST;
                        shot_moving_q = 1'b0;
                    end
                end
                else
                    hold_count = '0;
            end
            LEVER_DOWN:
            begin
                flywheel_on_q = 1'b1;
                mode_q        = MODE_BURST;
            end
            default: ;
        endcase

        // Jam guard: a long stall forces reverse, then the reverse run is counted.
        if (mode_q == MODE_BURST || mode_q == MODE_SINGLE)
        begin
            if (stall_count >= stall_limit)
                mode_q = MODE_REVERSE;
            if (feed_mag < stall_speed_thr && stall_count < stall_limit)
            begin
                stall_count   = stall_count + 16'd1;
                reverse_count = '0;
            end
            else if (stall_count == stall_limit && reverse_count < reverse_limit)
                reverse_count = reverse_count + 16'd1;
            else
                stall_count = '0;
        end

        d.at_speed = (fly_mag >= flywheel_min);
        if (!d.at_speed)
            mode_q = MODE_STOP;
        if ({1'b0, t.heat_now} + {1'b0, heat_margin} > {1'b0, t.heat_cap})
            mode_q = MODE_STOP;
        if (t.safe)
        begin
            mode_q        = MODE_STOP;
            flywheel_on_q = 1'b0;
        end
        if (mode_q == MODE_SINGLE)
        begin
            d.index_start = !shot_moving_q;
            shot_moving_q = t.err_open;
        end
        d.fw_en = flywheel_on_q;
        d.mode  = mode_q;
        return d;
    endfunction

    function automatic logic signed [15:0] speed_of(int unsigned mag);
        if (mag > 32767)
            return 16'sh8000;
        return $urandom_range(1) ? 16'(-int'(mag)) : 16'(mag);
    endfunction

    function automatic tick_t calm_tick(logic [1:0] lever);
        tick_t t;
        t.lever     = lever;
        t.safe      = 1'b0;
        t.key_start = 1'b0;
        t.key_stop  = 1'b0;
        t.left      = 1'b0;
        t.right     = 1'b0;
        t.fire      = 1'b0;
        t.feeder    = 16'sd5000;
        t.flywheel  = 16'sd20000;
        t.heat_now  = 16'd0;
        t.heat_cap  = 16'd1000;
        t.err_open  = 1'b0;
        return t;
    endfunction

    // Mostly plausible control ticks around the current thresholds, with a
    // share of fully random ones.
    function automatic tick_t random_tick();
        tick_t t;
        int    pick;
        if ($urandom_range(99) < 12)
        begin
            t.lever     = 2'($urandom);
            t.safe      = 1'($urandom);
            t.key_start = 1'($urandom);
            t.key_stop  = 1'($urandom);
            t.left      = 1'($urandom);
            t.right     = 1'($urandom);
            t.fire      = 1'($urandom);
            t.feeder    = 16'($urandom);
            t.flywheel  = 16'($urandom);
            t.heat_now  = 16'($urandom);
            t.heat_cap  = 16'($urandom);
            t.err_open  = 1'($urandom);
            return t;
        end
        pick = $urandom_range(99);
        if (pick < 65)
            t.lever = LEVER_MIDDLE;
        else if (pick < 80)
            t.lever = LEVER_DOWN;
        else if (pick < 90)
            t.lever = LEVER_UP;
        else
            t.lever = LEVER_INVALID;
        t.safe      = ($urandom_range(99) < 4);
        t.key_start = ($urandom_range(99) < 8);
        t.key_stop  = ($urandom_range(99) < 8);
        if ($urandom_range(99) < 15)
            left_level = !left_level;
        t.left      = left_level;
        t.right     = ($urandom_range(99) < 30);
        t.fire      = 1'($urandom);
        t.err_open  = ($urandom_range(99) < 40);
        if ($urandom_range(99) < 50)
            t.feeder = speed_of($urandom_range(0, stall_speed_thr));
        else
            t.feeder = speed_of($urandom_range(0, 32768));
        if ($urandom_range(99) < 85)
            t.flywheel = speed_of($urandom_range(flywheel_min, 32768));
        else
            t.flywheel = speed_of($urandom_range(0, flywheel_min));
        if ($urandom_range(99) < 85)
        begin
            t.heat_cap = 16'($urandom_range(heat_margin, 65535));
            t.heat_now = 16'($urandom_range(0, t.heat_cap - heat_margin));
        end
        else
        begin
            t.heat_cap = 16'($urandom);
            t.heat_now = 16'($urandom);
        end
        return t;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch in %s at %0t ns: got %0d, expected %0d", field, $time, got, want);
        mismatch_count++;
    endtask

    task automatic reset_block();
        stall_speed_thr = RST_STALL_SPEED;
        stall_limit     = RST_STALL_LIMIT;
        reverse_limit   = RST_REVERSE_LIMIT;
        flywheel_min    = RST_FLYWHEEL_MIN;
        heat_margin     = RST_HEAT_MARGIN;
        hold_limit      = RST_HOLD_TO_BURST;
        latch_q         = 1'b0;
        flywheel_on_q   = 1'b0;
        mode_q          = MODE_STOP;
        prev_left_q     = 1'b0;
        shot_moving_q   = 1'b0;
        hold_count      = '0;
        stall_count     = '0;
        reverse_count   = '0;
        rst_n           = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_STALL_SPEED:   stall_speed_thr = value[14:0];
            CFG_STALL_LIMIT:   stall_limit     = value;
            CFG_REVERSE_LIMIT: reverse_limit   = value;
            CFG_FLYWHEEL_MIN:  flywheel_min    = value[14:0];
            CFG_HEAT_MARGIN:   heat_margin     = value;
            CFG_HOLD_TO_BURST: hold_limit      = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_registers(int stall_speed, int stall_lim, int reverse_lim,
                                   int fly_min, int margin, int hold);
        write_register(CFG_STALL_SPEED, 16'(stall_speed));
        write_register(CFG_STALL_LIMIT, 16'(stall_lim));
        write_register(CFG_REVERSE_LIMIT, 16'(reverse_lim));
        write_register(CFG_FLYWHEEL_MIN, 16'(fly_min));
        write_register(CFG_HEAT_MARGIN, 16'(margin));
        write_register(CFG_HOLD_TO_BURST, 16'(hold));
    endtask

    task automatic send_tick(tick_t t);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_tick(t);
        do
            @(posedge clk);
        while (!s_tready);
        pending_decisions.push_back(decide_tick(t));
    endtask

    // Drops the input valid and waits until every accepted item has its result.
    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (receiver_hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            receiver_hold_cycles--;
        end
        else
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        decision_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_decisions.size() == 0)
                report_mismatch("unexpected result item", m_tdata, 0);
            else
            begin
                want = pending_decisions.pop_front();
                if (m_tdata[0] !== want.fw_en)
                    report_mismatch("flywheel_enable", m_tdata[0], want.fw_en);
                if (m_tdata[2:1] !== want.mode)
                    report_mismatch("feed_mode", m_tdata[2:1], want.mode);
                if (m_tdata[3] !== want.at_speed)
                    report_mismatch("flywheel_at_speed", m_tdata[3], want.at_speed);
                if (m_tdata[4] !== want.index_start)
                    report_mismatch("index_start", m_tdata[4], want.index_start);
            end
        end
    end

    task automatic test_directed();
        tick_t t;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_tick(calm_tick(LEVER_UP));
        t = calm_tick(LEVER_MIDDLE);
        t.key_start = 1'b1;
        send_tick(t);
        // A rising left edge starts a shot that stays open for one more item.
        t = calm_tick(LEVER_MIDDLE);
        t.left     = 1'b1;
        t.err_open = 1'b1;
        send_tick(t);
        t.err_open = 1'b0;
        send_tick(t);
        t = calm_tick(LEVER_MIDDLE);
        t.right = 1'b1;
        t.fire  = 1'b1;
        send_tick(t);
        t.fire = 1'b0;
        send_tick(t);
        t = calm_tick(LEVER_MIDDLE);
        t.key_stop = 1'b1;
        send_tick(t);
        send_tick(calm_tick(LEVER_DOWN));
        send_tick(calm_tick(LEVER_INVALID));
        t = calm_tick(LEVER_DOWN);
        t.feeder   = 16'sh8000;
        t.flywheel = 16'sh8000;
        send_tick(t);
        t.feeder   = 16'sh7FFF;
        t.flywheel = 16'sh7FFF;
        send_tick(t);
        t.flywheel = 16'sd999;
        send_tick(t);
        t.flywheel = -16'sd1000;
        send_tick(t);
        // The heat sum must not wrap at the top of the range.
        t = calm_tick(LEVER_DOWN);
        t.heat_now = 16'hFFFF;
        t.heat_cap = 16'hFFFF;
        send_tick(t);
        t.heat_now = 16'd0;
        t.heat_cap = 16'd10;
        send_tick(t);
        t.heat_now = 16'd1;
        send_tick(t);
        t = calm_tick(LEVER_DOWN);
        t.safe = 1'b1;
        send_tick(t);
        t = calm_tick(LEVER_INVALID);
        t.safe      = 1'b1;
        t.key_start = 1'b1;
        t.key_stop  = 1'b1;
        t.left      = 1'b1;
        t.right     = 1'b1;
        t.fire      = 1'b1;
        t.feeder    = -16'sd1;
        t.flywheel  = -16'sd1;
        t.heat_now  = 16'hFFFF;
        t.heat_cap  = 16'hFFFF;
        t.err_open  = 1'b1;
        send_tick(t);
        wait_drain();
    endtask

    task automatic test_hold_and_jam();
        tick_t t;
        apply_registers(32767, 3, 2, 1000, 10, 2);
        t = calm_tick(LEVER_MIDDLE);
        t.key_start = 1'b1;
        t.left      = 1'b1;
        t.feeder    = 16'sd0;
        repeat (6) send_tick(t);
        t = calm_tick(LEVER_DOWN);
        t.feeder = 16'sd0;
        repeat (8) send_tick(t);
        t.feeder = 16'sh8000;
        repeat (2) send_tick(t);
        wait_drain();
    endtask

    task automatic test_register_extremes();
        // Zero limits follow the same rules as any other register values.
        apply_registers(0, 0, 0, 0, 0, 0);
        repeat (40) send_tick(random_tick());
        wait_drain();
        apply_registers(32767, 1, 1, 0, 0, 1);
        repeat (40) send_tick(random_tick());
        wait_drain();
        // All-ones data also checks that the 15-bit registers drop the top bit.
        apply_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (40) send_tick(random_tick());
        wait_drain();
    endtask

    task automatic test_random_traffic(int snd_pct, int rcv_pct);
        sender_idle_pct   = snd_pct;
        receiver_idle_pct = rcv_pct;
        repeat (3)
        begin
            apply_registers($urandom_range(0, 3000), $urandom_range(1, 40),
                            $urandom_range(1, 20), $urandom_range(0, 5000),
                            $urandom_range(0, 2000), $urandom_range(1, 12));
            repeat (100) send_tick(random_tick());
            wait_drain();
        end
    endtask

    task automatic test_backpressure();
        sender_idle_pct      = 0;
        receiver_idle_pct    = 0;
        receiver_hold_cycles = 60;
        repeat (40) send_tick(random_tick());
        wait_drain();
    endtask

    task automatic test_drain_pause();
        sender_idle_pct   = 0;
        receiver_idle_pct = 47;
        repeat (25)
        begin
            send_tick(random_tick());
            wait_drain();
        end
    endtask

    initial
    begin
        reset_block();
        test_directed();
        test_hold_and_jam();
        test_register_extremes();
        test_random_traffic(22, 47);
        test_random_traffic(47, 22);
        test_random_traffic(0, 0);
        test_backpressure();
        test_drain_pause();
        wait_drain();
        repeat (10) @(posedge clk);
        if (pending_decisions.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("feeder_mode_jam_guard_tb: PASS");
        else
            $display("feeder_mode_jam_guard_tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
rtl/fmjg_pkg.sv
rtl/feeder_mode_jam_guard.sv
tb/sv/feeder_mode_jam_guard_tb.sv
